>>> rtl/assert_macros.svh
// Assertion macros for the checker file of the block.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on each rising edge, skipping cycles held in reset.
`define FTA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fixed timestep accumulator check failed");

// Check a property on each rising edge, reset cycles included.
`define FTA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("fixed timestep accumulator check failed");

`endif

>>> rtl/fta_pkg.sv
// Shared types, codes and constants of the fixed timestep accumulator.
// No dependencies; every other file but assert_macros.svh refers to it by scoped names.
package fta_pkg;

  localparam int unsigned MAX_CATCHUP = 64;
  localparam int unsigned EMIT_W      = $clog2(MAX_CATCHUP + 1);

  localparam logic [62:0] STEP_RESET = 63'd16666667;
  localparam logic [31:0] RATE_RESET = 32'd65536;
  localparam logic [31:0] HALF_LSB   = 32'd32768;

  // configuration register indexes
  localparam logic [1:0] CFG_STEP   = 2'd0;
  localparam logic [1:0] CFG_RATE   = 2'd1;
  localparam logic [1:0] CFG_PAUSED = 2'd2;

  // input modes carried on tuser
  localparam logic [1:0] MODE_ADVANCE = 2'd0;
  localparam logic [1:0] MODE_SAMPLE  = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NEG_DELTA = 3'd1;
  localparam logic [2:0] ST_FRAME_OVF = 3'd2;
  localparam logic [2:0] ST_SCALE_OVF = 3'd3;
  localparam logic [2:0] ST_ACC_OVF   = 3'd4;
  localparam logic [2:0] ST_TICK_OVF  = 3'd5;
  localparam logic [2:0] ST_CATCHUP   = 3'd6;
  localparam logic [2:0] ST_SOURCE    = 3'd7;

  typedef enum logic [1:0] {
    CMD_ADVANCE,
    CMD_SAMPLE,
    CMD_RESTART,
    CMD_IGNORE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [63:0] operand;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        step_valid;
    logic [63:0] step_tick;
    logic [62:0] step_length_ns;
    logic [63:0] frame_number;
    logic        last;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL_LO,
    S_MUL_HI,
    S_SCALE,
    S_SUM,
    S_DIV,
    S_COMMIT,
    S_EMIT
  } back_state_t;

endpackage

>>> rtl/fta_front.sv
// Front end: accepts input requests and classifies them into commands.
// Depends on fta_pkg.
module fta_front (
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [191:0]      s_tdata,
  input  logic [1:0]        s_tuser,
  input  logic              q_full,
  output logic              q_push,
  output fta_pkg::cmd_t     q_entry
);

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    unique case (s_tuser)
      fta_pkg::MODE_ADVANCE: begin
        q_entry.kind    = fta_pkg::CMD_ADVANCE;
        q_entry.operand = s_tdata[63:0];
      end
      fta_pkg::MODE_SAMPLE: begin
        q_entry.kind    = fta_pkg::CMD_SAMPLE;
        q_entry.operand = s_tdata[127:64];
      end
      fta_pkg::MODE_RESTART: begin
        q_entry.kind    = fta_pkg::CMD_RESTART;
        q_entry.operand = s_tdata[191:128];
      end
      default: begin
        q_entry.kind    = fta_pkg::CMD_IGNORE;
        q_entry.operand = '0;
      end
    endcase
  end

endmodule

>>> rtl/fta_queue.sv
// Two-entry command queue between front and back end.
// Depends on fta_pkg.
module fta_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fta_pkg::cmd_t push_entry,
  input  logic          pop,
  output fta_pkg::cmd_t pop_entry,
  output logic          not_empty,
  output logic          full
);

  fta_pkg::cmd_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign pop_entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/fta_back.sv
// Back end: scales, accumulates and divides, then emits the results.
// Holds the configuration registers and the timebase state. Depends on fta_pkg.
module fta_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [62:0]     cfg_data,
  input  logic            q_valid,
  input  fta_pkg::cmd_t   q_entry,
  output logic            q_pop,
  output logic            m_valid,
  input  logic            m_ready,
  output fta_pkg::result_t m_result
);

  localparam int unsigned EW = fta_pkg::EMIT_W;

  fta_pkg::back_state_t state;
  fta_pkg::back_state_t state_next;

  logic [62:0] fixed_step_ns;
  logic [31:0] rate_q16;
  logic        paused;

  logic [63:0] tick_count;
  logic [63:0] frame_count;
  logic [62:0] accumulated_ns;
  logic [63:0] previous_time;
  logic        has_previous;

  logic [63:0] delta;
  logic [63:0] sample_time;
  logic        is_sample;
  logic [63:0] plo;
  logic [63:0] phi;
  logic [63:0] total;
  logic [62:0] div_rem;
  logic [62:0] div_quo;
  logic [5:0]  div_cnt;
  logic [2:0]  emit_status;
  logic [EW-1:0] emit_left;

  logic [63:0] stamp_gap;
  logic        smp_err;
  logic        check_err;
  logic [95:0] prod;
  logic        scale_ovf;
  logic [63:0] rem_sh;
  logic        rem_ge;
  logic        tick_ovf;
  logic        catchup_ovf;
  logic        out_load;
  logic        emit_done;

  assign stamp_gap = q_entry.operand - previous_time;
  assign smp_err   = has_previous &&
                     (($signed(q_entry.operand) < $signed(previous_time)) || stamp_gap[63]);
  assign check_err = delta[63] || (&frame_count);
  assign prod      = {phi, 32'd0} + {32'd0, plo} + {64'd0, fta_pkg::HALF_LSB};
  // rounded value must fit 63 bits
  assign scale_ovf = |prod[95:79];
  assign rem_sh    = {div_rem, div_quo[62]};
  assign rem_ge    = rem_sh >= {1'b0, fixed_step_ns};
  assign tick_ovf  = {1'b0, div_quo} > ~tick_count;
  assign catchup_ovf = div_quo > 63'(fta_pkg::MAX_CATCHUP);
  assign emit_done = (emit_left == EW'(0)) || (emit_left == EW'(1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fta_pkg::S_IDLE: begin
        if (q_valid) begin
          if (q_entry.kind == fta_pkg::CMD_ADVANCE) begin
            state_next = fta_pkg::S_CHECK;
          end else if (q_entry.kind == fta_pkg::CMD_SAMPLE && !smp_err) begin
            state_next = fta_pkg::S_CHECK;
          end else begin
            state_next = fta_pkg::S_EMIT;
          end
        end
      end
      fta_pkg::S_CHECK:  state_next = check_err ? fta_pkg::S_EMIT : fta_pkg::S_MUL_LO;
      fta_pkg::S_MUL_LO: state_next = fta_pkg::S_MUL_HI;
      fta_pkg::S_MUL_HI: state_next = fta_pkg::S_SCALE;
      fta_pkg::S_SCALE: begin
        state_next = (scale_ovf || paused) ? fta_pkg::S_EMIT : fta_pkg::S_SUM;
      end
      fta_pkg::S_SUM:    state_next = total[63] ? fta_pkg::S_EMIT : fta_pkg::S_DIV;
      fta_pkg::S_DIV:    state_next = (div_cnt == 6'd0) ? fta_pkg::S_COMMIT : fta_pkg::S_DIV;
      fta_pkg::S_COMMIT: state_next = fta_pkg::S_EMIT;
      fta_pkg::S_EMIT: begin
        if (out_load && emit_done) begin
          state_next = fta_pkg::S_IDLE;
        end
      end
      default: state_next = fta_pkg::S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    q_pop    = (state == fta_pkg::S_IDLE) && q_valid;
    out_load = (state == fta_pkg::S_EMIT) && (!m_valid || m_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fta_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_step_ns <= fta_pkg::STEP_RESET;
      rate_q16      <= fta_pkg::RATE_RESET;
      paused        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fta_pkg::CFG_STEP: begin
          if (cfg_data != 63'd0) begin
            fixed_step_ns <= cfg_data;
          end
        end
        fta_pkg::CFG_RATE:   rate_q16 <= cfg_data[31:0];
        fta_pkg::CFG_PAUSED: paused   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      fta_pkg::S_IDLE: begin
        is_sample   <= (q_entry.kind == fta_pkg::CMD_SAMPLE);
        sample_time <= q_entry.operand;
        if (q_entry.kind == fta_pkg::CMD_SAMPLE) begin
          delta <= has_previous ? stamp_gap : 64'd0;
        end else begin
          delta <= q_entry.operand;
        end
      end
      fta_pkg::S_MUL_LO: plo <= {32'd0, delta[31:0]} * {32'd0, rate_q16};
      fta_pkg::S_MUL_HI: phi <= {32'd0, delta[63:32]} * {32'd0, rate_q16};
      fta_pkg::S_SCALE:  total <= {1'b0, accumulated_ns} + {1'b0, prod[78:16]};
      fta_pkg::S_SUM: begin
        div_rem <= '0;
        div_quo <= total[62:0];
        div_cnt <= 6'd62;
      end
      fta_pkg::S_DIV: begin
        // one quotient bit a cycle
        div_rem <= rem_ge ? 63'(rem_sh - {1'b0, fixed_step_ns}) : rem_sh[62:0];
        div_quo <= {div_quo[61:0], rem_ge};
        div_cnt <= div_cnt - 6'd1;
      end
      default: ;
    endcase
  end

  // timebase state and emission control
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      frame_count    <= '0;
      accumulated_ns <= '0;
      previous_time  <= '0;
      has_previous   <= 1'b0;
      emit_status    <= fta_pkg::ST_OK;
      emit_left      <= '0;
    end else begin
      unique case (state)
        fta_pkg::S_IDLE: begin
          emit_status <= fta_pkg::ST_OK;
          emit_left   <= '0;
          if (q_valid && q_entry.kind == fta_pkg::CMD_SAMPLE && smp_err) begin
            emit_status <= fta_pkg::ST_SOURCE;
          end
          if (q_valid && q_entry.kind == fta_pkg::CMD_RESTART) begin
            tick_count     <= q_entry.operand;
            frame_count    <= '0;
            accumulated_ns <= '0;
            previous_time  <= '0;
            has_previous   <= 1'b0;
          end
        end
        fta_pkg::S_CHECK: begin
          if (delta[63]) begin
            emit_status <= fta_pkg::ST_NEG_DELTA;
          end else if (&frame_count) begin
            emit_status <= fta_pkg::ST_FRAME_OVF;
          end
        end
        fta_pkg::S_SCALE: begin
          if (scale_ovf) begin
            emit_status <= fta_pkg::ST_SCALE_OVF;
          end else if (paused) begin
            // frame still advances while paused
            frame_count <= frame_count + 64'd1;
            if (is_sample) begin
              previous_time <= sample_time;
              has_previous  <= 1'b1;
            end
          end
        end
        fta_pkg::S_SUM: begin
          if (total[63]) begin
            emit_status <= fta_pkg::ST_ACC_OVF;
          end
        end
        fta_pkg::S_COMMIT: begin
          if (tick_ovf) begin
            emit_status <= fta_pkg::ST_TICK_OVF;
          end else if (catchup_ovf) begin
            emit_status <= fta_pkg::ST_CATCHUP;
          end else begin
            frame_count    <= frame_count + 64'd1;
            accumulated_ns <= div_rem;
            emit_left      <= div_quo[EW-1:0];
            if (is_sample) begin
              previous_time <= sample_time;
              has_previous  <= 1'b1;
            end
          end
        end
        fta_pkg::S_EMIT: begin
          if (out_load && emit_left != EW'(0)) begin
            tick_count <= tick_count + 64'd1;
            emit_left  <= emit_left - EW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (out_load) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_result.frame_number <= frame_count;
      if (emit_left == EW'(0)) begin
        m_result.status         <= emit_status;
        m_result.step_valid     <= 1'b0;
        m_result.step_tick      <= '0;
        m_result.step_length_ns <= '0;
        m_result.last           <= 1'b1;
      end else begin
        m_result.status         <= fta_pkg::ST_OK;
        m_result.step_valid     <= 1'b1;
        m_result.step_tick      <= tick_count + 64'd1;
        m_result.step_length_ns <= fixed_step_ns;
        m_result.last           <= (emit_left == EW'(1));
      end
    end
  end

endmodule

>>> rtl/fixed_timestep_accumulator_core.sv
// Top level of the fixed timestep accumulator: front end, queue, back end.
// Depends on fta_pkg, fta_front, fta_queue and fta_back.
//
// Input stream: tuser carries the mode (advance, sample, restart), tdata the
// delta, timestamp and start tick. Output stream: one request per result,
// tlast on the final result of an input item. Up to two items wait in the
// queue while the back end works on an earlier one.
// An advance reaching an idle back end gives its first result after pop, checks,
// two multiplies, a rounding add, an accumulator add, bit-serial division and a
// commit; steps follow one a cycle while the receiver takes them. Single results
// come from idle (restart, unused mode, source error), the checks (negative
// delta, frame overflow), scaling (scale overflow, paused), the sum (accumulator
// overflow) or the commit (tick overflow, catch-up limit, no whole step). The
// next item is taken once the last result is loaded. Configuration writes (step
// length, rate, pause) take effect at once; the user must make them only while
// the block is idle, which the block does not enforce. Reset clears the queue,
// the timebase state and the output valid flag and restores the configuration
// defaults. A stalled receiver holds the current result; the back end waits, and
// the input side stalls once the queue fills.
module fixed_timestep_accumulator_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,   // delta_ns, timestamp_ns, start_tick
  input  logic [1:0]   s_tuser,   // mode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [199:0] m_tdata,   // status, step_valid, step_tick, step_length_ns,
                                  // frame_number, zero fill
  output logic         m_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [62:0]  cfg_data
);

  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_valid;
  fta_pkg::cmd_t    push_entry;
  fta_pkg::cmd_t    pop_entry;
  fta_pkg::result_t result;

  fta_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  fta_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .not_empty  (q_valid),
    .full       (q_full)
  );

  fta_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_entry   (pop_entry),
    .q_pop     (q_pop),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .m_result  (result)
  );

  assign m_tdata = {5'd0, result.frame_number, result.step_length_ns, result.step_tick,
                    result.step_valid, result.status};
  assign m_tlast = result.last;

endmodule

>>> rtl/fta_checker.sv
// Port-level checks of the fixed timestep accumulator, bound to the top level.
// Depends on assert_macros.svh and fta_pkg.
`include "assert_macros.svh"

module fta_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [199:0] m_tdata,
  input logic         m_tlast
);

  `FTA_ASSERT(hold_result, clk, rst, m_tvalid && !m_tready |=> m_tvalid)
  `FTA_ASSERT_ALWAYS(reset_clears_output, clk, rst |=> !m_tvalid)
  `FTA_ASSERT(step_is_ok, clk, rst, m_tvalid && m_tdata[3] |-> m_tdata[2:0] == fta_pkg::ST_OK)
  `FTA_ASSERT(single_is_last, clk, rst, m_tvalid && !m_tdata[3] |-> m_tlast)

endmodule

bind fixed_timestep_accumulator_core fta_checker u_fta_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
